[rtl/core/keepalive_timeout_monitor_macros.svh]
// Assertion macros shared by the keep-alive timeout monitor RTL.
`ifndef KEEPALIVE_TIMEOUT_MONITOR_MACROS_SVH
`define KEEPALIVE_TIMEOUT_MONITOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KTM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keep-alive monitor check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define KTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keep-alive monitor check failed");

`endif

[rtl/core/ktm_pkg.sv]
// Package with constants and types of the keep-alive timeout monitor.
`timescale 1ns / 1ps
package ktm_pkg;

  localparam int SESSION_SLOTS = 16;
  localparam int IDX_W         = $clog2(SESSION_SLOTS);

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 4;
  localparam int ADDR_W    = 32;
  localparam int KA_W      = 16;
  localparam int TIME_W    = 32;
  localparam int SCALE_W   = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1500);

  localparam logic [CMD_W-1:0] CMD_CONNECT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACTIVITY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd3;

  // One request to the shared expiry unit.
  typedef struct packed {
    logic              load;
    logic [TIME_W-1:0] seen_ms;
    logic [KA_W-1:0]   ka_secs;
  } exp_req_t;

endpackage

[rtl/core/ktm_ifs.sv]
// Channel interfaces of the keep-alive timeout monitor.
`timescale 1ns / 1ps
interface ktm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  slot;
  logic [31:0] peer_address;
  logic [15:0] keep_alive_secs;
  logic        will_present;
  logic [31:0] now_ms;

  modport source (output valid, command, slot, peer_address, keep_alive_secs,
                  will_present, now_ms, input ready);
  modport sink (input valid, command, slot, peer_address, keep_alive_secs,
                will_present, now_ms, output ready);
endinterface

interface ktm_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] dropped_slot;
  logic       dropped;
  logic       will_due;
  logic       last;

  modport source (output valid, dropped_slot, dropped, will_due, last, input ready);
  modport sink (input valid, dropped_slot, dropped, will_due, last, output ready);
endinterface

interface ktm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/core/ktm_expiry_unit.sv]
// Shared multiply and compare unit that decides whether one session expired.
`timescale 1ns / 1ps
module ktm_expiry_unit (
  input  logic                         clk,
  input  ktm_pkg::exp_req_t            req,
  input  logic [ktm_pkg::TIME_W-1:0]   now,
  input  logic [ktm_pkg::SCALE_W-1:0]  scale,
  output logic                         expired
);
  import ktm_pkg::*;

  logic [TIME_W-1:0] limit;
  logic [TIME_W:0]   elapsed;
  logic              ka_nonzero;

  // Stage one: the limit product and the signed elapsed time are registered.
  always_ff @(posedge clk) begin
    if (req.load) begin
      limit      <= TIME_W'(req.ka_secs * scale);
      elapsed    <= {1'b0, now} - {1'b0, req.seen_ms};
      ka_nonzero <= (req.ka_secs != '0);
    end
  end

  // Stage two: a negative or zero elapsed time never expires.
  assign expired = ka_nonzero && !elapsed[TIME_W] && (elapsed[TIME_W-1:0] != '0) &&
                   (elapsed[TIME_W-1:0] > limit);

endmodule

[rtl/core/keepalive_timeout_monitor.sv]
// Top level of the keep-alive timeout monitor: session table and tick sequencer.
//
//   Channel  Direction  Handshake     Moves
//   item     in         valid/ready   one table command or one timeout tick
//   result   out        valid/ready   one dropped session or an empty tick report
//   cfg      in         valid/ready   timeout_scale, always ready
//
// A connect, activity or close command is handled at its transfer. A tick first
// runs every slot through the shared expiry unit (read, multiply, compare), then scans
// the slots: a slot that is not an expired live session is passed over; otherwise its
// address is read, the other slots are searched for a live, unexpired peer at that
// address, and the session is dropped if none is found. Reset is synchronous and
// clears all sessions and wills. A stalled result register holds the scan at any drop
// after the first and at the end of the tick.
`timescale 1ns / 1ps
`include "keepalive_timeout_monitor_macros.svh"
module keepalive_timeout_monitor (
  input  logic         clk,
  input  logic         rst,
  ktm_item_if.sink     item,
  ktm_result_if.source result,
  ktm_cfg_if.sink      cfg
);
  import ktm_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXP_RD   = 4'd1;
  localparam logic [3:0] S_EXP_MUL  = 4'd2;
  localparam logic [3:0] S_EXP_CMP  = 4'd3;
  localparam logic [3:0] S_SEL      = 4'd4;
  localparam logic [3:0] S_ADDR     = 4'd5;
  localparam logic [3:0] S_PEER_RD  = 4'd6;
  localparam logic [3:0] S_PEER_CMP = 4'd7;
  localparam logic [3:0] S_DROP     = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SESSION_SLOTS - 1);

  // Session table: the wide fields live in memories, flags in flip-flops.
  logic [TIME_W-1:0] seen_mem [SESSION_SLOTS];
  logic [KA_W-1:0]   ka_mem   [SESSION_SLOTS];
  logic [ADDR_W-1:0] addr_mem [SESSION_SLOTS];
  logic [SESSION_SLOTS-1:0] session_live;
  logic [SESSION_SLOTS-1:0] will_armed;
  logic [SESSION_SLOTS-1:0] exp_flag;

  logic [3:0]         state;
  logic [IDX_W-1:0]   k;
  logic [IDX_W-1:0]   i;
  logic [IDX_W-1:0]   j;
  logic [IDX_W-1:0]   rd_idx;
  logic [TIME_W-1:0]  rd_seen;
  logic [KA_W-1:0]    rd_ka;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  ref_addr;
  logic [TIME_W-1:0]  tick_now;
  logic [SCALE_W-1:0] timeout_scale;

  // The newest drop waits here until the scan knows whether it is the last one.
  logic               pend_v;
  logic [IDX_W-1:0]   pend_slot;
  logic               pend_will;

  logic               out_v;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_drop;
  logic               out_will;
  logic               out_last;

  logic               item_xfer;
  logic               slot_ok;
  logic [IDX_W-1:0]   wr_idx;
  logic               out_free;
  logic               out_load;
  logic               peer_ok;
  logic               drop_go;
  logic               expired;
  exp_req_t           req;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign item_xfer  = item.valid && item.ready;
  assign slot_ok    = (int'(item.slot) < SESSION_SLOTS);
  assign wr_idx     = IDX_W'(item.slot);
  assign out_free   = !out_v || result.ready;
  assign drop_go    = (state == S_DROP) && (!pend_v || out_free);
  // The result register takes a new report when a held drop moves out or the tick ends.
  assign out_load   = (drop_go && pend_v) || ((state == S_FIN) && out_free);

  // A slot may keep the candidate alive only if it is live and not expired itself.
  assign peer_ok = (j != i) && session_live[j] && !exp_flag[j];

  assign result.valid        = out_v;
  assign result.dropped_slot = out_slot;
  assign result.dropped      = out_drop;
  assign result.will_due     = out_will;
  assign result.last         = out_last;

  always_comb begin
    case (state)
      S_EXP_RD: rd_idx = k;
      S_SEL:    rd_idx = i;
      default:  rd_idx = j;
    endcase
  end

  // Table memories: one write on a connect or activity command, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (item_xfer && slot_ok) begin
      if (item.command == CMD_CONNECT) begin
        seen_mem[wr_idx] <= item.now_ms;
        ka_mem[wr_idx]   <= item.keep_alive_secs;
        addr_mem[wr_idx] <= item.peer_address;
      end else if (item.command == CMD_ACTIVITY && session_live[wr_idx]) begin
        seen_mem[wr_idx] <= item.now_ms;
      end
    end
    rd_seen <= seen_mem[rd_idx];
    rd_ka   <= ka_mem[rd_idx];
    rd_addr <= addr_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_scale <= SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      timeout_scale <= cfg.data;
    end
  end

  assign req.load    = (state == S_EXP_MUL);
  assign req.seen_ms = rd_seen;
  assign req.ka_secs = rd_ka;

  ktm_expiry_unit u_expiry (
    .clk     (clk),
    .req     (req),
    .now     (tick_now),
    .scale   (timeout_scale),
    .expired (expired)
  );

  // Expiry flags and scan data need no reset: a tick writes them before use.
  always_ff @(posedge clk) begin
    if (item_xfer && item.command == CMD_TICK) begin
      tick_now <= item.now_ms;
    end
    if (state == S_EXP_CMP) begin
      exp_flag[k] <= expired;
    end
    if (state == S_ADDR) begin
      ref_addr <= rd_addr;
    end
    if (drop_go) begin
      pend_slot <= i;
      pend_will <= will_armed[i];
    end
  end

  // Sequencer, session flags and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      k            <= '0;
      i            <= '0;
      j            <= '0;
      pend_v       <= 1'b0;
      out_v        <= 1'b0;
      out_slot     <= '0;
      out_drop     <= 1'b0;
      out_will     <= 1'b0;
      out_last     <= 1'b0;
      session_live <= '0;
      will_armed   <= '0;
    end else begin
      if (out_load) begin
        out_v <= 1'b1;
      end else if (out_v && result.ready) begin
        out_v <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_xfer) begin
            if (item.command == CMD_TICK) begin
              k     <= '0;
              state <= S_EXP_RD;
            end else if (slot_ok && item.command == CMD_CONNECT) begin
              session_live[wr_idx] <= 1'b1;
              will_armed[wr_idx]   <= item.will_present;
            end else if (slot_ok && item.command == CMD_CLOSE) begin
              session_live[wr_idx] <= 1'b0;
              will_armed[wr_idx]   <= 1'b0;
            end
          end
        end
        S_EXP_RD: begin
          state <= S_EXP_MUL;
        end
        S_EXP_MUL: begin
          state <= S_EXP_CMP;
        end
        S_EXP_CMP: begin
          if (k == IDX_LAST) begin
            i     <= '0;
            state <= S_SEL;
          end else begin
            k     <= k + 1'b1;
            state <= S_EXP_RD;
          end
        end
        S_SEL: begin
          if (session_live[i] && exp_flag[i]) begin
            state <= S_ADDR;
          end else if (i == IDX_LAST) begin
            state <= S_FIN;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_ADDR: begin
          j     <= '0;
          state <= S_PEER_RD;
        end
        S_PEER_RD: begin
          if (peer_ok) begin
            state <= S_PEER_CMP;
          end else if (j == IDX_LAST) begin
            state <= S_DROP;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_PEER_CMP: begin
          if (rd_addr == ref_addr) begin
            // A live peer at the same address keeps this session.
            if (i == IDX_LAST) begin
              state <= S_FIN;
            end else begin
              i     <= i + 1'b1;
              state <= S_SEL;
            end
          end else if (j == IDX_LAST) begin
            state <= S_DROP;
          end else begin
            j     <= j + 1'b1;
            state <= S_PEER_RD;
          end
        end
        S_DROP: begin
          if (drop_go) begin
            if (pend_v) begin
              out_slot <= SLOT_W'(pend_slot);
              out_drop <= 1'b1;
              out_will <= pend_will;
              out_last <= 1'b0;
            end
            pend_v          <= 1'b1;
            session_live[i] <= 1'b0;
            will_armed[i]   <= 1'b0;
            if (i == IDX_LAST) begin
              state <= S_FIN;
            end else begin
              i     <= i + 1'b1;
              state <= S_SEL;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_slot <= pend_v ? SLOT_W'(pend_slot) : '0;
            out_drop <= pend_v;
            out_will <= pend_v && pend_will;
            out_last <= 1'b1;
            pend_v   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A held drop never outlives its tick.
  `KTM_ASSERT_IMPL(a_pend_in_tick, pend_v, state != S_IDLE)
  // An empty tick report is always the final result of its tick.
  `KTM_ASSERT_IMPL(a_empty_is_last, out_v && !out_drop, out_last)
  // A tick always starts the expiry pass.
  `KTM_ASSERT_NEXT(a_tick_starts, item_xfer && item.command == CMD_TICK, state == S_EXP_RD)
  // A dropped session is disconnected and its will disarmed.
  `KTM_ASSERT_NEXT(a_drop_clears, drop_go,
                   !session_live[$past(i)] && !will_armed[$past(i)] && pend_v)
  // The scan only considers a slot for a peer search if it is live and expired.
  `KTM_ASSERT_IMPL(a_addr_candidate, state == S_ADDR, session_live[i] && exp_flag[i])

endmodule

[bench/keepalive_timeout_monitor_test.sv]
// Self-checking testbench for the keep-alive timeout monitor with a built-in session predictor.
`timescale 1ns / 1ps
module keepalive_timeout_monitor_test;
  import ktm_pkg::*;

  // One command as it travels on the item channel.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] peer_address;
    logic [KA_W-1:0]   keep_alive_secs;
    logic              will_present;
    logic [TIME_W-1:0] now_ms;
  } session_cmd_t;

  // One report as it travels on the result channel.
  typedef struct packed {
    logic [SLOT_W-1:0] dropped_slot;
    logic              dropped;
    logic              will_due;
    logic              last;
  } drop_report_t;

  // This bound lies far beyond the worst tick, so it is only hit when the block hangs.
  localparam int unsigned DRAIN_LIMIT = 200000;
  // A comfortable margin for the block to settle before the scale register is touched.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS = 36;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_rx = 1'b0;

  ktm_item_if   item_if ();
  ktm_result_if result_if ();
  ktm_cfg_if    cfg_if ();

  keepalive_timeout_monitor dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // Commands waiting to be offered, and the drop reports the predictor says must come back.
  session_cmd_t pending_cmds[$];
  drop_report_t drop_reports_due[$];

  // Mirror of the session table and of the scale register.
  bit                live_mirror [SESSION_SLOTS];
  bit                will_mirror [SESSION_SLOTS];
  logic [TIME_W-1:0] seen_mirror [SESSION_SLOTS];
  logic [KA_W-1:0]   ka_mirror   [SESSION_SLOTS];
  logic [ADDR_W-1:0] addr_mirror [SESSION_SLOTS];
  logic [SCALE_W-1:0] scale_now = SCALE_RESET;

  // Stimulus state: a running millisecond clock and a few shared client addresses, so that
  // several sessions often sit behind one address and the peer rule gets exercised.
  logic [TIME_W-1:0] stim_ms;
  logic [ADDR_W-1:0] addr_pool [3];

  int unsigned errors = 0;
  int unsigned items_taken = 0;
  int unsigned ticks_sent = 0;
  int unsigned drops_seen = 0;
  int unsigned wills_seen = 0;
  int unsigned empty_ticks = 0;
  int unsigned scale_writes = 0;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // A session has lapsed when its signed elapsed time is positive and beyond
  // keep_alive times the scale. A keep-alive of zero switches the check off.
  function automatic bit lapsed(int s, logic [TIME_W-1:0] now);
    longint elapsed;
    longint limit;
    elapsed = longint'({32'd0, now}) - longint'({32'd0, seen_mirror[s]});
    limit = longint'({48'd0, ka_mirror[s]}) * longint'({48'd0, scale_now});
    return (ka_mirror[s] != '0) && (elapsed > 0) && (elapsed > limit);
  endfunction

  // Applies one accepted command to the mirror and queues the reports a tick causes.
  task automatic predict_session_cmd(session_cmd_t c);
    drop_report_t found[$];
    bit peer_ok;
    int s;
    s = c.slot;
    case (c.command)
      CMD_CONNECT: begin
        live_mirror[s] = 1'b1;
        seen_mirror[s] = c.now_ms;
        ka_mirror[s]   = c.keep_alive_secs;
        addr_mirror[s] = c.peer_address;
        will_mirror[s] = c.will_present;
      end
      CMD_ACTIVITY: begin
        // Activity on a free slot leaves the stale last-seen time alone.
        if (live_mirror[s]) seen_mirror[s] = c.now_ms;
      end
      CMD_CLOSE: begin
        live_mirror[s] = 1'b0;
        will_mirror[s] = 1'b0;
      end
      CMD_TICK: begin
        ticks_sent++;
        // Ascending scan. A slot dropped earlier in this tick no longer counts as a
        // live peer for the slots after it.
        for (int i = 0; i < SESSION_SLOTS; i++) begin
          if (!live_mirror[i] || !lapsed(i, c.now_ms)) continue;
          peer_ok = 1'b0;
          for (int j = 0; j < SESSION_SLOTS; j++) begin
            if (j != i && live_mirror[j] && addr_mirror[j] == addr_mirror[i] &&
                !lapsed(j, c.now_ms)) peer_ok = 1'b1;
          end
          if (peer_ok) continue;
          live_mirror[i] = 1'b0;
          found.push_back('{SLOT_W'(i), 1'b1, will_mirror[i], 1'b0});
          will_mirror[i] = 1'b0;
        end
        // A tick that drops nothing still reports once, as an empty closing report.
        if (found.size() == 0) found.push_back('{'0, 1'b0, 1'b0, 1'b1});
        else found[found.size()-1].last = 1'b1;
        foreach (found[k]) drop_reports_due.push_back(found[k]);
      end
    endcase
  endtask

  // Driver: offers queued commands with random gaps, and feeds every accepted transfer to
  // the predictor. The valid line gets at most one assignment per edge.
  session_cmd_t offered;
  int unsigned send_gap = 0;
  int unsigned calm_sends = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        predict_session_cmd(offered);
        items_taken++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          offered = pending_cmds.pop_front();
          item_if.valid           <= 1'b1;
          item_if.command         <= offered.command;
          item_if.slot            <= offered.slot;
          item_if.peer_address    <= offered.peer_address;
          item_if.keep_alive_secs <= offered.keep_alive_secs;
          item_if.will_present    <= offered.will_present;
          item_if.now_ms          <= offered.now_ms;
          // Occasional runs of back-to-back transfers between the gapped stretches.
          if (calm_sends > 0) begin
            calm_sends--;
            send_gap = 0;
          end else begin
            if ($urandom_range(0, 19) == 0) calm_sends = $urandom_range(10, 30);
            send_gap = idle_span();
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each report transfer against the oldest prediction and drives a
  // randomly gapped ready. The long hold-off overrides the random pattern.
  drop_report_t got_report;
  drop_report_t want_report;
  int unsigned recv_gap = 0;
  int unsigned calm_recv = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got_report = '{result_if.dropped_slot, result_if.dropped, result_if.will_due,
                       result_if.last};
        if (got_report.dropped) drops_seen++;
        if (got_report.will_due) wills_seen++;
        if (!got_report.dropped) empty_ticks++;
        if (drop_reports_due.size() == 0) begin
          $display("%0t: unexpected report slot %0d dropped %0b will %0b last %0b", $time,
                   got_report.dropped_slot, got_report.dropped, got_report.will_due,
                   got_report.last);
          errors++;
        end else begin
          want_report = drop_reports_due.pop_front();
          if (got_report !== want_report) begin
            $display("%0t: expected slot %0d dropped %0b will %0b last %0b, got slot %0d dropped %0b will %0b last %0b",
                     $time, want_report.dropped_slot, want_report.dropped,
                     want_report.will_due, want_report.last, got_report.dropped_slot,
                     got_report.dropped, got_report.will_due, got_report.last);
            errors++;
          end
        end
      end
      if (hold_rx) begin
        result_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (calm_recv > 0) begin
          calm_recv--;
        end else if ($urandom_range(0, 3) == 0) begin
          recv_gap = idle_span();
          if ($urandom_range(0, 9) == 0) calm_recv = $urandom_range(20, 80);
        end
      end
    end
  end

  // Long receiver hold-off early in the random traffic. The sender keeps offering, so a
  // tick with several drops parks in the result register and the item channel backs up.
  initial begin
    while (items_taken < 60) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (1200) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic push_cmd(logic [CMD_W-1:0] cmd, int unsigned slot, logic [ADDR_W-1:0] addr,
                          logic [KA_W-1:0] ka, logic will, logic [TIME_W-1:0] now);
    pending_cmds.push_back('{cmd, SLOT_W'(slot), addr, ka, will, now});
  endtask

  // Waits until every command has been taken and every report has come back, then lets
  // the block settle. This is also where the sender sits idle with nothing outstanding.
  task automatic drain_results();
    int unsigned waited;
    while (pending_cmds.size() != 0) @(posedge clk);
    @(posedge clk);
    while (item_if.valid) @(posedge clk);
    waited = 0;
    while (drop_reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (drop_reports_due.size() != 0) begin
      $display("%0t: %0d predicted reports never arrived", $time, drop_reports_due.size());
      errors++;
      drop_reports_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the scale register through its own channel; the mirror follows at the transfer.
  task automatic write_scale(logic [SCALE_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    scale_now = value;
    scale_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic. Most commands form sensible session lifecycles around the running
  // clock; unused fields always carry noise, and a slice of commands is pure noise.
  // Once per call, all sixteen slots are connected and then timed out together.
  task automatic add_traffic(int unsigned count);
    int unsigned r;
    int unsigned span;
    int unsigned fill_at;
    logic [ADDR_W-1:0] addr;
    logic [KA_W-1:0] ka_pick;
    logic [TIME_W-1:0] tick_ms;
    span = (scale_now == '0) ? 4 : scale_now;
    fill_at = $urandom_range(0, count - 1);
    for (int n = 0; n < count; n++) begin
      if (n == fill_at) begin
        for (int s = 0; s < SESSION_SLOTS; s++)
          push_cmd(CMD_CONNECT, s, $urandom, 16'd1, 1'($urandom), stim_ms);
        stim_ms += 2 * span + 1;
        push_cmd(CMD_TICK, $urandom, $urandom, KA_W'($urandom), 1'($urandom), stim_ms);
      end
      r = $urandom_range(0, 99);
      addr = ($urandom_range(0, 4) != 0) ? addr_pool[$urandom_range(0, 2)] : $urandom;
      if (r < 30) begin
        r = $urandom_range(0, 9);
        ka_pick = (r < 7) ? KA_W'($urandom_range(1, 4)) : (r < 8) ? '0 : KA_W'($urandom);
        push_cmd(CMD_CONNECT, $urandom, addr, ka_pick, 1'($urandom), stim_ms);
      end else if (r < 52) begin
        stim_ms += $urandom_range(0, span / 4);
        push_cmd(CMD_ACTIVITY, $urandom, $urandom, KA_W'($urandom), 1'($urandom), stim_ms);
      end else if (r < 60) begin
        push_cmd(CMD_CLOSE, $urandom, $urandom, KA_W'($urandom), 1'($urandom), $urandom);
      end else if (r < 80) begin
        stim_ms += $urandom_range(0, 5) * span + $urandom_range(0, span);
        // Now and then the tick carries a time behind the sessions' last-seen times.
        tick_ms = ($urandom_range(0, 9) == 0) ? stim_ms - $urandom_range(1, 2 * span) : stim_ms;
        push_cmd(CMD_TICK, $urandom, $urandom, KA_W'($urandom), 1'($urandom), tick_ms);
      end else begin
        push_cmd(CMD_CONNECT + CMD_W'($urandom), $urandom, $urandom, KA_W'($urandom),
                 1'($urandom), $urandom);
      end
    end
  endtask

  logic [SCALE_W-1:0] phase_scales [5];

  initial begin
    item_if.valid           = 1'b0;
    item_if.command         = CMD_CONNECT;
    item_if.slot            = '0;
    item_if.peer_address    = '0;
    item_if.keep_alive_secs = '0;
    item_if.will_present    = 1'b0;
    item_if.now_ms          = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.data             = '0;
    result_if.ready         = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset scale of 1500 ms per keep-alive second.
    // A tick on an empty table gives one empty report.
    push_cmd(CMD_TICK, 0, '0, '0, 1'b0, '0);
    // Extreme addresses and keep-alives.
    push_cmd(CMD_CONNECT, 0, 32'h0000_0000, 16'd1, 1'b1, 32'd0);
    push_cmd(CMD_CONNECT, 15, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'd0);
    // Slot 1 will lapse, but slot 2 at the same address has keep-alive off and shields it.
    push_cmd(CMD_CONNECT, 1, 32'h0A00_0001, 16'd2, 1'b1, 32'd100);
    push_cmd(CMD_CONNECT, 2, 32'h0A00_0001, 16'd0, 1'b1, 32'd100);
    // Two sessions behind one address lapse together; the scan order drops both.
    push_cmd(CMD_CONNECT, 3, 32'hC0A8_0001, 16'd1, 1'b1, 32'd100);
    push_cmd(CMD_CONNECT, 4, 32'hC0A8_0001, 16'd1, 1'b0, 32'd100);
    // Activity refreshes a live session, and is ignored on a free slot.
    push_cmd(CMD_CONNECT, 5, 32'h7F00_0001, 16'd1, 1'b1, 32'd1000);
    push_cmd(CMD_ACTIVITY, 5, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd1600);
    push_cmd(CMD_ACTIVITY, 6, 32'h5555_5555, 16'hAAAA, 1'b0, 32'd1600);
    // Last-seen at the top of the clock, so every later tick sees a negative or zero elapsed time.
    push_cmd(CMD_CONNECT, 7, 32'hAC10_0001, 16'd1, 1'b1, 32'hFFFF_FFFF);
    // A clean close takes a session out without a will.
    push_cmd(CMD_CONNECT, 8, 32'hAC10_0002, 16'd1, 1'b1, 32'd100);
    push_cmd(CMD_CLOSE, 8, 32'hAAAA_AAAA, 16'h5555, 1'b1, 32'hAAAA_AAAA);
    // Elapsed exactly at the limit stays, one past it drops.
    push_cmd(CMD_TICK, 0, '0, '0, 1'b0, 32'd1500);
    push_cmd(CMD_TICK, 0, '0, '0, 1'b0, 32'd1501);
    push_cmd(CMD_TICK, 0, '0, '0, 1'b0, 32'd3200);
    // Closing the shield lets slot 1 go on the next tick.
    push_cmd(CMD_CLOSE, 2, '0, '0, 1'b0, '0);
    push_cmd(CMD_TICK, 0, '0, '0, 1'b0, 32'd3201);
    push_cmd(CMD_TICK, 0, '0, '0, 1'b0, 32'd3202);
    push_cmd(CMD_TICK, 15, '1, '1, 1'b1, 32'hFFFF_FFFF);
    drain_results();

    // Random phases, each at its own scale, written while the block is idle.
    phase_scales = '{16'd1, 16'hFFFF, 16'd0, SCALE_W'($urandom_range(2, 65534)), SCALE_RESET};
    stim_ms = $urandom_range(32'h0100_0000, 32'hA000_0000);
    foreach (phase_scales[p]) begin
      write_scale(phase_scales[p]);
      foreach (addr_pool[k]) addr_pool[k] = $urandom;
      // At the largest scale and keep-alive the limit sits just below the full clock range.
      if (phase_scales[p] == 16'hFFFF) begin
        push_cmd(CMD_CONNECT, 9, $urandom, 16'hFFFF, 1'b1, 32'd0);
        push_cmd(CMD_TICK, 0, '0, '0, 1'b0, 32'hFFFF_FFFF);
      end
      add_traffic(PHASE_ITEMS);
      drain_results();
    end

    repeat (50) @(posedge clk);
    $display("Ran %0d commands with %0d ticks across %0d timeout scale settings.",
             items_taken, ticks_sent, scale_writes + 1);
    $display("Checked %0d dropped sessions, %0d wills due and %0d empty tick reports.",
             drops_seen, wills_seen, empty_ticks);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #8_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
